>>> rtl/core/counting_semaphore_wait_queue_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the semaphore core
// Clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_CORE_DEFINES_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_CORE_DEFINES_SVH

// same-cycle implication
`define CSEM_ASSERT_SAME(label, clk_i, rst_i, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error("semaphore core check failed");

// next-cycle implication
`define CSEM_ASSERT_NEXT(label, clk_i, rst_i, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error("semaphore core check failed");

`endif

>>> rtl/core/csem_pkg.sv
// ----------------------------------------------------------------------------
// csem_pkg
// Shared widths, codes and controller types for the semaphore core.
// ----------------------------------------------------------------------------
package csem_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int COUNT_BITS  = 16;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int OCC_BITS    = $clog2(QUEUE_DEPTH + 1);

  // fixed port widths
  localparam int STATUS_W = 3;
  localparam int WOKEN_W  = 8;
  localparam int CNT_W    = 16;
  localparam int WAIT_W   = 5;
  localparam int CFG_W    = 16;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED     = 3'd0,
    ST_BLOCKED     = 3'd1,
    ST_INCREMENTED = 3'd2,
    ST_WOKEN       = 3'd3,
    ST_QUEUE_FULL  = 3'd4,
    ST_OVERFLOW    = 3'd5
  } csem_status_t;

  typedef enum logic {
    CS_IDLE,
    CS_EXEC
  } csem_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;  // capture incoming request
    logic exec;      // apply request, load result register
  } csem_cmd_t;

endpackage

>>> rtl/core/csem_ctrl.sv
// ----------------------------------------------------------------------------
// csem_ctrl
// Request sequencer: capture, execute, result-valid tracking.
// ----------------------------------------------------------------------------
module csem_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output csem_pkg::csem_cmd_t cmd
);

  csem_pkg::csem_state_t state, state_next;
  logic out_valid_next;
  logic slot_free;

  // result register can take a new result
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      csem_pkg::CS_IDLE: begin
        if (in_valid) state_next = csem_pkg::CS_EXEC;
      end
      csem_pkg::CS_EXEC: begin
        if (slot_free) state_next = csem_pkg::CS_IDLE;
      end
      default: state_next = csem_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.load_req = 1'b0;
    cmd.exec     = 1'b0;
    case (state)
      csem_pkg::CS_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      csem_pkg::CS_EXEC: begin
        cmd.exec = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.exec) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= csem_pkg::CS_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> rtl/core/csem_datapath.sv
// ----------------------------------------------------------------------------
// csem_datapath
// Count register, waiter FIFO with pointers, result register.
// ----------------------------------------------------------------------------
module csem_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  csem_pkg::csem_cmd_t                 cmd,
  input  logic                                req_action,
  input  logic [csem_pkg::ID_BITS-1:0]        req_thread_id,
  input  logic                                cfg_we,
  input  logic [csem_pkg::CFG_W-1:0]          cfg_wdata,
  output logic [csem_pkg::STATUS_W-1:0]       res_status,
  output logic [csem_pkg::WOKEN_W-1:0]        res_woken_id,
  output logic [csem_pkg::CNT_W-1:0]          res_count,
  output logic [csem_pkg::WAIT_W-1:0]         res_waiters
);

  localparam logic [csem_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [csem_pkg::OCC_BITS-1:0]   OCC_FULL  =
    csem_pkg::OCC_BITS'(csem_pkg::QUEUE_DEPTH);
  localparam logic [csem_pkg::PTR_BITS-1:0]   PTR_LAST  =
    csem_pkg::PTR_BITS'(csem_pkg::QUEUE_DEPTH - 1);

  // captured request
  logic                          req_up;
  logic [csem_pkg::ID_BITS-1:0]  req_id;

  // semaphore state
  logic [csem_pkg::COUNT_BITS-1:0] count, count_next;
  logic [csem_pkg::PTR_BITS-1:0]   head, head_next;
  logic [csem_pkg::PTR_BITS-1:0]   tail, tail_next;
  logic [csem_pkg::OCC_BITS-1:0]   occ, occ_next;

  logic [csem_pkg::ID_BITS-1:0] fifo_mem [csem_pkg::QUEUE_DEPTH];
  logic [csem_pkg::ID_BITS-1:0] head_data;   // registered read at head
  logic                         push;
  csem_pkg::csem_status_t       stat;
  logic [csem_pkg::ID_BITS-1:0] woken;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_up <= req_action;
      req_id <= req_thread_id;
    end
  end

  // request decode; an idle cycle always precedes exec, so head_data is current
  always_comb begin
    count_next = count;
    head_next  = head;
    tail_next  = tail;
    occ_next   = occ;
    push       = 1'b0;
    woken      = '0;
    stat       = csem_pkg::ST_GRANTED;
    if (!req_up) begin
      if (count != '0) begin
        count_next = count - 1'b1;
        stat       = csem_pkg::ST_GRANTED;
      end else if (occ != OCC_FULL) begin
        push      = 1'b1;
        tail_next = (tail == PTR_LAST) ? '0 : tail + 1'b1;
        occ_next  = occ + 1'b1;
        stat      = csem_pkg::ST_BLOCKED;
      end else begin
        stat = csem_pkg::ST_QUEUE_FULL;
      end
    end else begin
      if (occ == '0) begin
        if (count == COUNT_MAX) begin
          stat = csem_pkg::ST_OVERFLOW;
        end else begin
          count_next = count + 1'b1;
          stat       = csem_pkg::ST_INCREMENTED;
        end
      end else begin
        woken     = head_data;
        head_next = (head == PTR_LAST) ? '0 : head + 1'b1;
        occ_next  = occ - 1'b1;
        stat      = csem_pkg::ST_WOKEN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      head  <= '0;
      tail  <= '0;
      occ   <= '0;
    end else begin
      if (cfg_we) count <= csem_pkg::COUNT_BITS'(cfg_wdata);
      else if (cmd.exec) count <= count_next;
      if (cmd.exec) begin
        head <= head_next;
        tail <= tail_next;
        occ  <= occ_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && push) fifo_mem[tail] <= req_id;
    head_data <= fifo_mem[head];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status   <= stat;
      res_woken_id <= csem_pkg::WOKEN_W'(woken);
      res_count    <= csem_pkg::CNT_W'(count_next);
      res_waiters  <= csem_pkg::WAIT_W'(occ_next);
    end
  end

endmodule

>>> rtl/core/counting_semaphore_wait_queue_core.sv
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue_core
// Counting semaphore with a FIFO of blocked thread ids.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake             Payload
// request   in   in_valid / in_ready   action, thread_id
// result    out  out_valid / out_ready status, woken_id, count_now, waiters_now
// config    in   cfg_we                cfg_wdata (initial count)
//
// Each request is captured in the idle state, then executed against the
// count and queue pointers in the exec state. The waiter memory read is registered, which sets
// the idle capture cycle between executions.
// Synchronous reset clears count, pointers and occupancy; queue slots are
// not cleared. A stalled result holds execution; a new request is still
// captured while the previous result waits.
//
`include "counting_semaphore_wait_queue_core_defines.svh"

module counting_semaphore_wait_queue_core (
  input  logic                             clk,
  input  logic                             rst,
  // request channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             action,
  input  logic [csem_pkg::ID_BITS-1:0]     thread_id,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [csem_pkg::STATUS_W-1:0]    status,
  output logic [csem_pkg::WOKEN_W-1:0]     woken_id,
  output logic [csem_pkg::CNT_W-1:0]       count_now,
  output logic [csem_pkg::WAIT_W-1:0]      waiters_now,
  // config: initial count, loads the count immediately
  input  logic                             cfg_we,
  input  logic [csem_pkg::CFG_W-1:0]       cfg_wdata
);

  csem_pkg::csem_cmd_t cmd;

  // sequencer: one request in flight, result register handshake
  csem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // count, waiter FIFO and result register
  csem_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .req_action    (action),
    .req_thread_id (thread_id),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .res_status    (status),
    .res_woken_id  (woken_id),
    .res_count     (count_now),
    .res_waiters   (waiters_now)
  );

  // one request at a time: a capture is always followed by a busy cycle
  `CSEM_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)

  // woken id is only nonzero for a wake result
  `CSEM_ASSERT_SAME(a_woken_only, clk, rst, out_valid && (status != csem_pkg::ST_WOKEN), woken_id == '0)

  // occupancy never exceeds the queue depth
  `CSEM_ASSERT_SAME(a_occ_bound, clk, rst, out_valid, waiters_now <= csem_pkg::WAIT_W'(csem_pkg::QUEUE_DEPTH))

endmodule
